// ===== hw/rtl/avpm_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// avpm_pkg
// Shared types and constants for the affine viewport point mapper.
// ---------------------------------------------------------------------------
package avpm_pkg;

    localparam int COORD_W     = 16;
    localparam int COEF_W      = 32;
    localparam int HALF_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int QUEUE_DEPTH = 4;
    // quotient bits resolved by the divider, one per stage
    localparam int DIV_STEPS   = 31;

    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    localparam logic [1:0] CMD_AFFINE = 2'd0;
    localparam logic [1:0] CMD_AXIS   = 2'd1;
    localparam logic [1:0] CMD_LENGTH = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_AB,
        REG_COEF_CD,
        REG_TRANSLATE_EF,
        REG_BOX_ORIGIN,
        REG_BOX_SIZE,
        REG_VIEW_ORIGIN,
        REG_VIEW_SIZE
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] d;
        logic signed [COEF_W-1:0] e;
        logic signed [COEF_W-1:0] f;
        logic signed [HALF_W-1:0] bx;
        logic signed [HALF_W-1:0] by;
        logic        [HALF_W-1:0] bw;
        logic        [HALF_W-1:0] bh;
        logic signed [HALF_W-1:0] vx;
        logic signed [HALF_W-1:0] vy;
        logic        [HALF_W-1:0] vw;
        logic        [HALF_W-1:0] vh;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic               has_rotation;
        logic               divide_fault;
    } out_item_t;

    // point in integer user space, handed from front to back
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic               is_len;
    } q_item_t;

    // queue status seen by the front
    typedef struct packed {
        logic push;
        logic full;
    } q_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/avpm_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// avpm_queue
// Short FIFO between the affine front and the viewport back.
// ---------------------------------------------------------------------------
module avpm_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire avpm_pkg::q_item_t  push_item,
    output logic                    full,
    output logic                    q_valid,
    output avpm_pkg::q_item_t       q_item,
    input  wire logic               pop
);

    localparam int PTR_W = $clog2(avpm_pkg::QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    avpm_pkg::q_item_t mem_reg [avpm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full    = (count_reg == CNT_W'(avpm_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];

    // advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // write entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/avpm_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// avpm_front
// Accepts input beats, decodes the command and applies the fixed point
// affine, producing integer user-space coordinates for the queue.
// ---------------------------------------------------------------------------
module avpm_front #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire avpm_pkg::cfg_t     cfg,
    input  wire logic               src_valid,
    output logic                    src_stall,
    input  wire avpm_pkg::in_item_t src_item,
    output avpm_pkg::q_ctl_t        q_ctl,
    input  wire logic               q_full,
    output avpm_pkg::q_item_t       push_item
);

    localparam int PW = avpm_pkg::COORD_W + avpm_pkg::COEF_W;
    localparam int SW = PW + 2;

    logic                 en;
    logic                 is_len, is_axis;

    logic                 s1_valid_reg;
    logic                 s1_len_reg;
    logic signed [PW-1:0] xa_reg, yc_reg, xb_reg, yd_reg;

    logic                 s2_valid_reg;
    logic                 s2_len_reg;
    logic signed [SW-1:0] sum_x_reg, sum_y_reg;

    logic                 s3_valid_reg;
    logic                 s3_len_reg;
    logic signed [31:0]   px_reg, py_reg;

    // truncate toward zero, then saturate to 32 bits
    function automatic logic signed [31:0] fix_sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] adj;
        logic signed [SW-1:0] sh;
        adj = v + (v[SW-1] ? SW'((64'd1 << FRAC_BITS) - 64'd1) : SW'(0));
        sh  = adj >>> FRAC_BITS;
        if (sh > SW'(avpm_pkg::S32_MAX))
            return avpm_pkg::S32_MAX;
        else if (sh < SW'(avpm_pkg::S32_MIN))
            return avpm_pkg::S32_MIN;
        else
            return sh[31:0];
    endfunction

    // hold the whole front while its last stage cannot drain
    assign en        = !(s3_valid_reg && q_full);
    assign src_stall = !en;

    assign is_len  = (src_item.command == avpm_pkg::CMD_LENGTH);
    assign is_axis = (src_item.command == avpm_pkg::CMD_AXIS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= src_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // products, shear terms dropped for the axis and length commands
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_len_reg <= is_len;
            xa_reg     <= PW'(src_item.x_coord) * PW'(cfg.a);
            yc_reg     <= (is_len || is_axis) ? '0 : PW'(src_item.y_coord) * PW'(cfg.c);
            xb_reg     <= (is_len || is_axis) ? '0 : PW'(src_item.x_coord) * PW'(cfg.b);
            yd_reg     <= PW'(src_item.y_coord) * PW'(cfg.d);
        end
    end

    // sum with translation, e omitted for the length command
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_len_reg <= s1_len_reg;
            sum_x_reg  <= SW'(xa_reg) + SW'(yc_reg) + (s1_len_reg ? SW'(0) : SW'(cfg.e));
            sum_y_reg  <= SW'(xb_reg) + SW'(yd_reg) + SW'(cfg.f);
        end
    end

    // drop fraction
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_len_reg <= s2_len_reg;
            px_reg     <= fix_sat(sum_x_reg);
            py_reg     <= fix_sat(sum_y_reg);
        end
    end

    assign q_ctl.push       = s3_valid_reg && !q_full;
    assign q_ctl.full       = q_full;
    assign push_item.px     = px_reg;
    assign push_item.py     = py_reg;
    assign push_item.is_len = s3_len_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/avpm_divider.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// avpm_divider
// Pipelined signed division by a 16-bit unsigned divisor, one quotient bit
// per stage, quotient saturated to signed 32 bits.
// ---------------------------------------------------------------------------
module avpm_divider (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic signed [48:0]            num,
    input  wire logic [avpm_pkg::HALF_W-1:0]   den,
    output logic signed [31:0]                 quo
);

    localparam int N  = avpm_pkg::DIV_STEPS;
    localparam int RW = avpm_pkg::HALF_W;

    logic [RW-1:0] rem_reg [N+1];
    logic [N-1:0]  nq_reg  [N+1];
    logic          neg_reg [N+1];
    logic          sat_reg [N+1];

    logic [RW-1:0] rem_next [N];
    logic [N-1:0]  nq_next  [N];

    logic          neg_in;
    logic [47:0]   mag_in;
    logic          sat_in;

    // magnitude and overflow check at entry
    always_comb
    begin
        neg_in = num[48];
        mag_in = 48'(neg_in ? -num : num);
        sat_in = (mag_in >= 48'({den, 31'b0}));
    end

    // restoring step per stage
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            logic [RW:0] r2;
            logic        ge;
            r2          = {rem_reg[i], nq_reg[i][N-1]};
            ge          = (r2 >= {1'b0, den});
            rem_next[i] = ge ? RW'(r2 - {1'b0, den}) : r2[RW-1:0];
            nq_next[i]  = {nq_reg[i][N-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= mag_in[46:31];
            nq_reg[0]  <= mag_in[30:0];
            neg_reg[0] <= neg_in;
            sat_reg[0] <= sat_in;
            for (int i = 0; i < N; i++)
            begin
                rem_reg[i+1] <= rem_next[i];
                nq_reg[i+1]  <= nq_next[i];
                neg_reg[i+1] <= neg_reg[i];
                sat_reg[i+1] <= sat_reg[i];
            end
        end
    end

    // restore sign, clamp on overflow
    always_comb
    begin
        if (sat_reg[N])
            quo = neg_reg[N] ? avpm_pkg::S32_MIN : avpm_pkg::S32_MAX;
        else if (neg_reg[N])
            quo = -$signed({1'b0, nq_reg[N]});
        else
            quo = $signed({1'b0, nq_reg[N]});
    end

endmodule
`default_nettype wire

// ===== hw/rtl/avpm_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// avpm_back
// Maps queued user-space points from the viewBox to the box: offset,
// scale, divide, add origin, and holds the result beat.
// ---------------------------------------------------------------------------
module avpm_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire avpm_pkg::cfg_t      cfg,
    input  wire logic                q_valid,
    input  wire avpm_pkg::q_item_t   q_item,
    output logic                     pop,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output avpm_pkg::out_item_t      res_item
);

    localparam int N = avpm_pkg::DIV_STEPS;

    logic               en;

    logic               b1_valid_reg, b1_len_reg;
    logic signed [31:0] dx_reg, dy_reg;
    logic               b2_valid_reg, b2_len_reg;
    logic signed [48:0] nx_reg, ny_reg;

    logic               dv_valid_reg [N+1];
    logic               dv_len_reg   [N+1];

    logic signed [31:0] qx, qy;
    logic signed [15:0] org_x;
    logic               len_o;
    logic               fault_x, fault_y;
    avpm_pkg::out_item_t res_next;

    logic                res_valid_reg;
    avpm_pkg::out_item_t res_item_reg;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v > 33'(avpm_pkg::S32_MAX))
            return avpm_pkg::S32_MAX;
        else if (v < 33'(avpm_pkg::S32_MIN))
            return avpm_pkg::S32_MIN;
        else
            return v[31:0];
    endfunction

    // hold every stage while the result beat waits
    assign en  = !(res_valid_reg && res_stall);
    assign pop = en && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i <= N; i++)
            begin
                dv_valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            b1_valid_reg    <= q_valid;
            b2_valid_reg    <= b1_valid_reg;
            dv_valid_reg[0] <= b2_valid_reg;
            for (int i = 0; i < N; i++)
            begin
                dv_valid_reg[i+1] <= dv_valid_reg[i];
            end
            res_valid_reg   <= dv_valid_reg[N];
        end
    end

    // offset from the viewBox origin, scale by the box size
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_len_reg <= q_item.is_len;
            dx_reg     <= sat33(33'(q_item.px) - (q_item.is_len ? 33'sd0 : 33'(cfg.vx)));
            dy_reg     <= sat33(33'(q_item.py) - 33'(cfg.vy));
            b2_len_reg <= b1_len_reg;
            nx_reg     <= 49'(dx_reg) * 49'($signed({1'b0, cfg.bw}));
            ny_reg     <= 49'(dy_reg) * 49'($signed({1'b0, cfg.bh}));
            dv_len_reg[0] <= b2_len_reg;
            for (int i = 0; i < N; i++)
            begin
                dv_len_reg[i+1] <= dv_len_reg[i];
            end
        end
    end

    avpm_divider u_div_x (
        .clk (clk),
        .en  (en),
        .num (nx_reg),
        .den (cfg.vw),
        .quo (qx)
    );

    avpm_divider u_div_y (
        .clk (clk),
        .en  (en),
        .num (ny_reg),
        .den (cfg.vh),
        .quo (qy)
    );

    // add box origin, substitute on a zero view size
    always_comb
    begin
        len_o   = dv_len_reg[N];
        org_x   = len_o ? 16'sd0 : cfg.bx;
        fault_x = (cfg.vw == '0);
        fault_y = !len_o && (cfg.vh == '0);
        res_next.out_x = fault_x ? 32'(org_x) : sat33(33'(qx) + 33'(org_x));
        if (len_o)
            res_next.out_y = '0;
        else if (fault_y)
            res_next.out_y = 32'(cfg.by);
        else
            res_next.out_y = sat33(33'(qy) + 33'(cfg.by));
        res_next.has_rotation = (cfg.b != '0) || (cfg.c != '0);
        res_next.divide_fault = fault_x || fault_y;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_item_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/affine_viewport_point_mapper.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// affine_viewport_point_mapper
// Affine transform of user-space points and viewBox-to-box mapping.
// ---------------------------------------------------------------------------
// Takes one point beat per cycle while not stalled and returns one result
// beat per point, in order. A point passes three front stages (multiply,
// sum, truncate), the four-entry queue, two back stages (offset, scale),
// the pipelined dividers (one quotient bit per stage) and the output
// register. Both sides stall independently; the queue absorbs front
// results while the output waits. The user must keep configuration
// static while points are in flight; the block does not enforce it.
module affine_viewport_point_mapper #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [avpm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [avpm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                src_valid,
    output logic                                     src_stall,
    input  wire avpm_pkg::in_item_t                  src_item,
    output logic                                     res_valid,
    input  wire logic                                res_stall,
    output avpm_pkg::out_item_t                      res_item
);

    // identity affine, unit box and viewBox
    localparam avpm_pkg::cfg_t CFG_RESET = '{
        a:       32'(64'd1 << FRAC_BITS),
        d:       32'(64'd1 << FRAC_BITS),
        bw:      16'd1,
        bh:      16'd1,
        vw:      16'd1,
        vh:      16'd1,
        default: '0
    };

    avpm_pkg::cfg_t    cfg_reg, cfg_next;
    avpm_pkg::q_ctl_t  q_ctl;
    avpm_pkg::q_item_t push_item, q_item;
    logic              q_full, q_valid, q_pop;

    // decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                avpm_pkg::REG_COEF_AB:
                begin
                    cfg_next.a = cfg_data[31:0];
                    cfg_next.b = cfg_data[63:32];
                end
                avpm_pkg::REG_COEF_CD:
                begin
                    cfg_next.c = cfg_data[31:0];
                    cfg_next.d = cfg_data[63:32];
                end
                avpm_pkg::REG_TRANSLATE_EF:
                begin
                    cfg_next.e = cfg_data[31:0];
                    cfg_next.f = cfg_data[63:32];
                end
                avpm_pkg::REG_BOX_ORIGIN:
                begin
                    cfg_next.bx = cfg_data[15:0];
                    cfg_next.by = cfg_data[31:16];
                end
                avpm_pkg::REG_BOX_SIZE:
                begin
                    cfg_next.bw = cfg_data[15:0];
                    cfg_next.bh = cfg_data[31:16];
                end
                avpm_pkg::REG_VIEW_ORIGIN:
                begin
                    cfg_next.vx = cfg_data[15:0];
                    cfg_next.vy = cfg_data[31:16];
                end
                avpm_pkg::REG_VIEW_SIZE:
                begin
                    cfg_next.vw = cfg_data[15:0];
                    cfg_next.vh = cfg_data[31:16];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    avpm_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .q_ctl     (q_ctl),
        .q_full    (q_full),
        .push_item (push_item)
    );

    avpm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_ctl.push),
        .push_item (push_item),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (q_pop)
    );

    avpm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    // queue never written while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_ctl.push |-> !q_ctl.full)
        else $error("queue push while full");

    // queue never read while empty
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue pop while empty");

    // a fault only with a zero view dimension
    a_fault_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_item.divide_fault) |-> (cfg_reg.vw == '0 || cfg_reg.vh == '0))
        else $error("divide fault without zero view size");

endmodule
`default_nettype wire
